// ===== sv/snow_pkg.sv =====
// ----------------------------------------------------------------------------
// SNOW-Vi package
// Payload types, configuration indexes and the AES round helpers.
// ----------------------------------------------------------------------------
package snow_pkg;

	typedef struct packed {
		logic        new_message;
		logic [63:0] text_low;
		logic [63:0] text_high;
	} snow_in_t;

	typedef struct packed {
		logic [63:0] cipher_low;
		logic [63:0] cipher_high;
	} snow_out_t;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_IV_LO = 3'd4;
	localparam logic [2:0] REG_IV_HI = 3'd5;

	localparam logic [15:0] GA_POLY = 16'h4a6d;
	localparam logic [15:0] GB_POLY = 16'hcc87;
	localparam int unsigned INIT_ROUNDS = 16;

	// datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic init;
		logic key_lo;
		logic key_hi;
		logic capture;
		logic saved;
	} snow_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [15:0] mulx(input logic [15:0] v, input logic [15:0] poly);
		return {v[14:0], 1'b0} ^ (v[15] ? poly : 16'h0000);
	endfunction

	// byte i of the 128-bit word sits at bits 8i+7:8i
	function automatic logic [127:0] aes_round(input logic [127:0] x);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r + 4 * c] = SBOX[x[8 * (r + 4 * ((c + r) % 4)) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4 * c];
			a1 = t[4 * c + 1];
			a2 = t[4 * c + 2];
			a3 = t[4 * c + 3];
			all = a0 ^ a1 ^ a2 ^ a3;
			o[32 * c +: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
			o[32 * c + 8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
			o[32 * c + 16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			o[32 * c + 24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return o;
	endfunction

	function automatic logic [127:0] sigma(input logic [127:0] x);
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			o[8 * i +: 8] = x[8 * (4 * (i % 4) + i / 4) +: 8];
		end
		return o;
	endfunction

endpackage

// ===== sv/snow_datapath.sv =====
// ----------------------------------------------------------------------------
// SNOW-Vi datapath
// LFSRs, FSM registers and the one-round update; result register.
// ----------------------------------------------------------------------------
module snow_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  snow_pkg::snow_cmd_t cmd,
	input  logic [63:0]        key_q [4],
	input  logic [63:0]        iv_q [2],
	input  logic [127:0]       text,
	output logic [127:0]       result
);
	import snow_pkg::*;

	logic [15:0]  a_q [16];
	logic [15:0]  b_q [16];
	logic [127:0] r1_q, r2_q, r3_q, res_q, text_q;
	logic [15:0]  na [8];
	logic [15:0]  nb [8];
	logic [127:0] z, naw, bh, tmp, r1_next;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			na[i] = a_q[i + 7] ^ b_q[i] ^ mulx(a_q[i], GA_POLY);
			nb[i] = b_q[i + 8] ^ mulx(b_q[i], GB_POLY) ^ a_q[i];
			bh[16 * i +: 16] = b_q[i + 8];
			naw[16 * i +: 16] = na[i];
		end
		for (int i = 0; i < 4; i++) begin
			z[32 * i +: 32]   = (bh[32 * i +: 32] + r1_q[32 * i +: 32]) ^ r2_q[32 * i +: 32];
			tmp[32 * i +: 32] = r2_q[32 * i +: 32] + r3_q[32 * i +: 32];
		end
		if (cmd.init) begin
			naw = naw ^ z;
		end
		r1_next = sigma(tmp);
		if (cmd.key_lo) begin
			r1_next = r1_next ^ {key_q[1], key_q[0]};
		end
		if (cmd.key_hi) begin
			r1_next = r1_next ^ {key_q[3], key_q[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < 4; i++) begin
				a_q[i]      <= iv_q[0][16 * i +: 16];
				a_q[i + 4]  <= iv_q[1][16 * i +: 16];
				a_q[i + 8]  <= key_q[0][16 * i +: 16];
				a_q[i + 12] <= key_q[1][16 * i +: 16];
				b_q[i]      <= '0;
				b_q[i + 4]  <= '0;
				b_q[i + 8]  <= key_q[2][16 * i +: 16];
				b_q[i + 12] <= key_q[3][16 * i +: 16];
			end
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= {key_q[1], key_q[0]};
		end else if (cmd.step) begin
			for (int i = 0; i < 8; i++) begin
				a_q[i]     <= a_q[i + 8];
				a_q[i + 8] <= naw[16 * i +: 16];
				b_q[i]     <= b_q[i + 8];
				b_q[i + 8] <= nb[i];
			end
			r3_q <= aes_round(r2_q) ^ naw;
			r2_q <= aes_round(r1_q);
			r1_q <= r1_next;
		end
	end

	// hold the text of a new-message word through the init rounds
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			text_q <= text;
		end
		if (cmd.capture) begin
			res_q <= (cmd.saved ? text_q : text) ^ z;
		end
	end

	assign result = res_q;

endmodule

// ===== sv/snow_ctrl.sv =====
// ----------------------------------------------------------------------------
// SNOW-Vi controller
// Sequences load, sixteen init rounds and the data round; output handshake.
// ----------------------------------------------------------------------------
module snow_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                new_message,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output snow_pkg::snow_cmd_t cmd
);
	import snow_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_INIT, S_DATA} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       free;

	// output register free after this edge
	assign free     = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !free;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					if (new_message) begin
						cmd.load = 1'b1;
					end else begin
						cmd.step    = 1'b1;
						cmd.capture = 1'b1;
					end
				end
			end
			S_INIT: begin
				cmd.step   = 1'b1;
				cmd.init   = 1'b1;
				cmd.key_lo = (cnt_q == 4'd14);
				cmd.key_hi = (cnt_q == 4'd15);
			end
			S_DATA: begin
				if (free) begin
					cmd.step    = 1'b1;
					cmd.capture = 1'b1;
					cmd.saved   = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_INIT;
						cnt_q   <= '0;
					end
				end
				S_INIT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(INIT_ROUNDS - 1)) begin
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_step_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step)) else $error("load and step together");
	a_init_to_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT && cnt_q == 4'd15) |=> state_q == S_DATA)
		else $error("init did not end in data round");
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> free) else $error("result overwritten");

endmodule

// ===== sv/snow_vi_stream_cipher.sv =====
// A plain word's result is registered on its accept edge; a new_message word
// passes through load on the accept edge, 16 init rounds and the data round.
// Throughput: one word per cycle while no message starts and out_stall is low.
// Reset zeroes state, LFSRs, FSM and config registers, not text_q or res_q.
// ----------------------------------------------------------------------------
// SNOW-Vi stream cipher top level
// Configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module snow_vi_stream_cipher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  snow_pkg::snow_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output snow_pkg::snow_out_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import snow_pkg::*;

	logic [63:0]  key_q [4];
	logic [63:0]  iv_q [2];
	snow_cmd_t    cmd;
	logic [127:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			iv_q[0] <= '0;
			iv_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0:  key_q[0] <= cfg_data;
				REG_KEY1:  key_q[1] <= cfg_data;
				REG_KEY2:  key_q[2] <= cfg_data;
				REG_KEY3:  key_q[3] <= cfg_data;
				REG_IV_LO: iv_q[0]  <= cfg_data;
				REG_IV_HI: iv_q[1]  <= cfg_data;
				default: ;
			endcase
		end
	end

	snow_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.new_message (in_data.new_message),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd)
	);

	snow_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key_q  (key_q),
		.iv_q   (iv_q),
		.text   ({in_data.text_high, in_data.text_low}),
		.result (result)
	);

	assign out_data.cipher_low  = result[63:0];
	assign out_data.cipher_high = result[127:64];

endmodule
